// ----- src/pdri_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pdri_pkg;

   localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [19:0] PI_Q16 = 20'sd205887;
   localparam logic signed [16:0] YAW_PI = 17'sd25736;
   localparam logic signed [16:0] YAW_TWO_PI = 17'sd51472;
   localparam logic [3:0] CORDIC_LAST = 4'd15;
   localparam logic [3:0] ATT_LAST = 4'd3;
   localparam logic [3:0] POS_LAST = 4'd7;
   localparam logic [3:0] DIV_LAST = 4'd1;
   // ceil(2^30 / 25), exact floor division by 25 below 2^30
   localparam logic [25:0] RECIP_25 = 26'd42949673;
   // half of 200 * 2^29
   localparam logic [57:0] HALF_DIV = 58'd53687091200;
   localparam logic [7:0] HALF_TICK = 8'd100;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_OFFSET_X = 3'd0;
   localparam csr_index_type CSR_OFFSET_Y = 3'd1;
   localparam csr_index_type CSR_VEH_HEIGHT = 3'd2;
   localparam csr_index_type CSR_INIT_X = 3'd3;
   localparam csr_index_type CSR_INIT_Y = 3'd4;
   localparam csr_index_type CSR_INIT_YAW = 3'd5;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] yaw_rate;
      logic signed [31:0] terrain_height;
      logic signed [15:0] terrain_roll;
      logic signed [15:0] terrain_pitch;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] heading;
      logic signed [23:0] roll_rate;
      logic signed [23:0] pitch_rate;
      logic signed [31:0] z_rate;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COR_OLD,
      ST_ATT,
      ST_ATT_FIN,
      ST_COR_NEW,
      ST_POS,
      ST_DIV,
      ST_DONE
   } core_state_type;

   function automatic logic signed [19:0] cordic_atan(input logic [3:0] i);
      logic signed [19:0] r;
      unique case (i)
         4'd0: r = 20'sd51472;
         4'd1: r = 20'sd30386;
         4'd2: r = 20'sd16055;
         4'd3: r = 20'sd8150;
         4'd4: r = 20'sd4091;
         4'd5: r = 20'sd2047;
         4'd6: r = 20'sd1024;
         4'd7: r = 20'sd512;
         4'd8: r = 20'sd256;
         4'd9: r = 20'sd128;
         4'd10: r = 20'sd64;
         4'd11: r = 20'sd32;
         4'd12: r = 20'sd16;
         4'd13: r = 20'sd8;
         4'd14: r = 20'sd4;
         4'd15: r = 20'sd2;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/pdri_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdri_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pdri_pkg::req_item_type req_data,
   output pdri_pkg::queue_out_type q_out,
   input  logic                  q_pop
);
   import pdri_pkg::*;

   req_item_type mem_ff [2];
   req_item_type mem_in [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop = q_pop && (count_ff != 2'd0);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = req_data;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/pdri_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdri_core (
   input  logic                    clock,
   input  logic                    reset,
   input  pdri_pkg::queue_out_type q_out,
   output logic                    q_pop,
   input  logic                    csr_valid,
   input  pdri_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pdri_pkg::rsp_item_type  rsp_data
);
   import pdri_pkg::*;

   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
      logic               flip;
   } cordic_type;

   function automatic cordic_type cordic_init(input logic signed [15:0] ang);
      cordic_type r;
      logic signed [19:0] z;
      z = 20'(ang) <<< 3;
      r.x = CORDIC_GAIN;
      r.y = 20'sd0;
      r.flip = 1'b0;
      r.z = z;
      if (z > HALF_PI_Q16) begin
         r.z = z - PI_Q16;
         r.flip = 1'b1;
      end else if (z < -HALF_PI_Q16) begin
         r.z = z + PI_Q16;
         r.flip = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] round_q16(input logic signed [57:0] v);
      logic [57:0] m;
      logic signed [58:0] r;
      m = v[57] ? 58'(-v) : 58'(v);
      m = (m + 58'd32768) >> 16;
      r = v[57] ? -59'($signed({1'b0, m})) : 59'($signed({1'b0, m}));
      if (r > 59'sd32767) begin
         return 16'sh7fff;
      end else if (r < -59'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   core_state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic ph_ff, ph_in;
   logic signed [19:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [18:0] vh_ff, vh_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] last_z_ff, last_z_in;
   logic signed [15:0] last_roll_ff, last_roll_in, last_pitch_ff, last_pitch_in;
   req_item_type item_ff, item_in;
   logic signed [9:0] ystep_ff, ystep_in;
   logic signed [19:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic signed [19:0] c_ff, c_in, s_ff, s_in;
   logic signed [61:0] prod_ff, prod_in;
   logic signed [57:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic signed [34:0] ys_ff, ys_in, yc_ff, yc_in;
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in;
   rsp_item_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic take, out_load, out_free, last_step;
   logic signed [19:0] xs, ysh, nx, ny, atan_v;
   logic signed [34:0] mul_a;
   logic signed [26:0] mul_b;
   logic signed [57:0] prod58, div_src;
   logic [57:0] div_abs, div_sum;
   logic [25:0] div_t;
   logic [22:0] div_q;
   logic [31:0] div_step;
   logic [16:0] yr_abs;
   logic [13:0] yr_t;
   logic [39:0] yr_p;
   logic [9:0] yr_q;
   logic signed [16:0] yaw_sum;
   logic signed [15:0] yaw_wrap;
   cordic_type init_old, init_new;
   logic signed [32:0] z_sum;
   logic signed [31:0] z_sat;
   logic signed [16:0] d_roll, d_pitch;
   logic signed [24:0] r_roll, r_pitch;
   logic signed [32:0] d_z;
   logic signed [40:0] r_z;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_out.valid) state_in = ST_COR_OLD;
         ST_COR_OLD: if (cnt_ff == CORDIC_LAST) state_in = ST_ATT;
         ST_ATT: if (ph_ff && cnt_ff == ATT_LAST) state_in = ST_ATT_FIN;
         ST_ATT_FIN: state_in = ST_COR_NEW;
         ST_COR_NEW: if (cnt_ff == CORDIC_LAST) state_in = ST_POS;
         ST_POS: if (ph_ff && cnt_ff == POS_LAST) state_in = ST_DIV;
         ST_DIV: if (ph_ff && cnt_ff == DIV_LAST) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      take = 1'b0;
      out_load = 1'b0;
      last_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: take = q_out.valid;
         ST_COR_OLD, ST_COR_NEW: last_step = (cnt_ff == CORDIC_LAST);
         ST_ATT: last_step = (cnt_ff == ATT_LAST);
         ST_POS: last_step = (cnt_ff == POS_LAST);
         ST_DIV: last_step = (cnt_ff == DIV_LAST);
         ST_DONE: out_load = out_free;
         default: take = 1'b0;
      endcase
   end
   assign q_pop = take;

   // cordic step
   assign atan_v = cordic_atan(cnt_ff);
   assign xs = cx_ff >>> cnt_ff;
   assign ysh = cy_ff >>> cnt_ff;
   assign nx = (cz_ff >= 0) ? cx_ff - ysh : cx_ff + ysh;
   assign ny = (cz_ff >= 0) ? cy_ff + xs : cy_ff - xs;

   // yaw increment, round(yaw_rate / 200)
   assign yr_abs = q_out.item.yaw_rate[15] ? 17'(-18'(q_out.item.yaw_rate))
                                          : 17'(q_out.item.yaw_rate);
   assign yr_t = 14'((yr_abs + 17'(HALF_TICK)) >> 3);
   assign yr_p = 40'(yr_t) * 40'(RECIP_25);
   assign yr_q = yr_p[39:30];

   assign yaw_sum = 17'(yaw_ff) + 17'(ystep_ff);
   always_comb begin
      if (yaw_sum > YAW_PI) begin
         yaw_wrap = 16'(yaw_sum - YAW_TWO_PI);
      end else if (yaw_sum < -YAW_PI) begin
         yaw_wrap = 16'(yaw_sum + YAW_TWO_PI);
      end else begin
         yaw_wrap = yaw_sum[15:0];
      end
   end
   assign init_old = cordic_init(yaw_ff);
   assign init_new = cordic_init(yaw_wrap);

   // shared multiplier operands
   always_comb begin
      mul_a = 35'sd0;
      mul_b = 27'sd0;
      priority case (state_ff)
         ST_ATT: begin
            unique case (cnt_ff[1:0])
               2'd0: begin mul_a = 35'(item_ff.terrain_roll); mul_b = 27'(c_ff); end
               2'd1: begin mul_a = 35'(item_ff.terrain_pitch); mul_b = 27'(s_ff); end
               2'd2: begin mul_a = 35'(item_ff.terrain_roll); mul_b = 27'(s_ff); end
               default: begin mul_a = 35'(item_ff.terrain_pitch); mul_b = 27'(c_ff); end
            endcase
         end
         ST_POS: begin
            unique case (cnt_ff[2:0])
               3'd0: begin mul_a = 35'(c_ff); mul_b = 27'(item_ff.speed); end
               3'd1: begin mul_a = 35'(s_ff); mul_b = 27'(item_ff.speed); end
               3'd2: begin mul_a = 35'(s_ff); mul_b = 27'(item_ff.yaw_rate); end
               3'd3: begin mul_a = 35'(c_ff); mul_b = 27'(item_ff.yaw_rate); end
               3'd4: begin mul_a = ys_ff; mul_b = 27'(ox_ff); end
               3'd5: begin mul_a = yc_ff; mul_b = 27'(oy_ff); end
               3'd6: begin mul_a = yc_ff; mul_b = 27'(ox_ff); end
               default: begin mul_a = ys_ff; mul_b = 27'(oy_ff); end
            endcase
         end
         ST_DIV: begin
            mul_a = 35'($signed({1'b0, div_t}));
            mul_b = 27'($signed({1'b0, RECIP_25}));
         end
         default: mul_a = 35'sd0;
      endcase
   end

   // rounded division by 200 * 2^29
   assign div_src = cnt_ff[0] ? acc_b_ff : acc_a_ff;
   assign div_abs = div_src[57] ? 58'(-div_src) : 58'(div_src);
   assign div_sum = div_abs + HALF_DIV;
   assign div_t = div_sum[57:32];
   assign div_q = prod_ff[52:30];
   assign div_step = div_src[57] ? 32'(-33'({1'b0, div_q})) : 32'(div_q);
   assign prod58 = prod_ff[57:0];

   // height and rates
   assign z_sum = 33'(item_ff.terrain_height) + 33'({1'b0, vh_ff});
   assign z_sat = (z_sum > 33'sd2147483647) ? 32'sh7fffffff :
                  (z_sum < -33'sd2147483648) ? 32'sh80000000 : z_sum[31:0];
   assign d_roll = 17'(roll_ff) - 17'(last_roll_ff);
   assign d_pitch = 17'(pitch_ff) - 17'(last_pitch_ff);
   assign d_z = 33'(z_sat) - 33'(last_z_ff);
   assign r_roll = (25'(d_roll) <<< 7) + (25'(d_roll) <<< 6) + (25'(d_roll) <<< 3);
   assign r_pitch = (25'(d_pitch) <<< 7) + (25'(d_pitch) <<< 6) + (25'(d_pitch) <<< 3);
   assign r_z = (41'(d_z) <<< 7) + (41'(d_z) <<< 6) + (41'(d_z) <<< 3);

   always_comb begin
      ox_in = ox_ff;
      oy_in = oy_ff;
      vh_in = vh_ff;
      yaw_in = yaw_ff;
      x_in = x_ff;
      y_in = y_ff;
      last_z_in = last_z_ff;
      last_roll_in = last_roll_ff;
      last_pitch_in = last_pitch_ff;
      item_in = item_ff;
      ystep_in = ystep_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      flip_in = flip_ff;
      c_in = c_ff;
      s_in = s_ff;
      prod_in = prod_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      ys_in = ys_ff;
      yc_in = yc_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      rsp_in = rsp_ff;
      cnt_in = cnt_ff;
      ph_in = ph_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_X: ox_in = csr_wdata[19:0];
            CSR_OFFSET_Y: oy_in = csr_wdata[19:0];
            CSR_VEH_HEIGHT: vh_in = csr_wdata[18:0];
            CSR_INIT_X: x_in = csr_wdata;
            CSR_INIT_Y: y_in = csr_wdata;
            CSR_INIT_YAW: yaw_in = csr_wdata[15:0];
            default: ox_in = ox_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               item_in = q_out.item;
               ystep_in = q_out.item.yaw_rate[15] ? -10'($signed({1'b0, yr_q}))
                                                 : 10'($signed({1'b0, yr_q}));
               cx_in = init_old.x;
               cy_in = init_old.y;
               cz_in = init_old.z;
               flip_in = init_old.flip;
               cnt_in = 4'd0;
               ph_in = 1'b0;
            end
         end
         ST_COR_OLD, ST_COR_NEW: begin
            cx_in = nx;
            cy_in = ny;
            cz_in = (cz_ff >= 0) ? cz_ff - atan_v : cz_ff + atan_v;
            cnt_in = cnt_ff + 4'd1;
            if (last_step) begin
               c_in = flip_ff ? -nx : nx;
               s_in = flip_ff ? -ny : ny;
               cnt_in = 4'd0;
               ph_in = 1'b0;
            end
         end
         ST_ATT, ST_POS, ST_DIV: begin
            ph_in = ~ph_ff;
            if (!ph_ff) begin
               prod_in = mul_a * mul_b;
            end else begin
               cnt_in = last_step ? 4'd0 : cnt_ff + 4'd1;
               if (state_ff == ST_ATT) begin
                  unique case (cnt_ff[1:0])
                     2'd0: acc_a_in = prod58;
                     2'd1: acc_a_in = acc_a_ff + prod58;
                     2'd2: acc_b_in = -prod58;
                     default: acc_b_in = acc_b_ff + prod58;
                  endcase
               end else if (state_ff == ST_POS) begin
                  unique case (cnt_ff[2:0])
                     3'd0: acc_a_in = prod58 <<< 17;
                     3'd1: acc_b_in = prod58 <<< 17;
                     3'd2: ys_in = prod_ff[34:0];
                     3'd3: yc_in = prod_ff[34:0];
                     3'd4: acc_a_in = acc_a_ff - prod58;
                     3'd5: acc_a_in = acc_a_ff - prod58;
                     3'd6: acc_b_in = acc_b_ff + prod58;
                     default: acc_b_in = acc_b_ff - prod58;
                  endcase
               end else begin
                  if (cnt_ff[0]) begin
                     y_in = y_ff + div_step;
                  end else begin
                     x_in = x_ff + div_step;
                  end
               end
            end
         end
         ST_ATT_FIN: begin
            roll_in = round_q16(acc_a_ff);
            pitch_in = round_q16(acc_b_ff);
            yaw_in = yaw_wrap;
            cx_in = init_new.x;
            cy_in = init_new.y;
            cz_in = init_new.z;
            flip_in = init_new.flip;
            cnt_in = 4'd0;
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_in.pos_x = x_ff;
               rsp_in.pos_y = y_ff;
               rsp_in.pos_z = z_sat;
               rsp_in.roll = roll_ff;
               rsp_in.pitch = pitch_ff;
               rsp_in.heading = yaw_ff;
               rsp_in.roll_rate = (r_roll > 25'sd8388607) ? 24'sh7fffff :
                                  (r_roll < -25'sd8388608) ? 24'sh800000 : r_roll[23:0];
               rsp_in.pitch_rate = (r_pitch > 25'sd8388607) ? 24'sh7fffff :
                                   (r_pitch < -25'sd8388608) ? 24'sh800000 : r_pitch[23:0];
               rsp_in.z_rate = (r_z > 41'sd2147483647) ? 32'sh7fffffff :
                               (r_z < -41'sd2147483648) ? 32'sh80000000 : r_z[31:0];
               rsp_valid_in = 1'b1;
               last_roll_in = roll_ff;
               last_pitch_in = pitch_ff;
               last_z_in = z_sat;
            end
         end
         default: cnt_in = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ystep_ff <= ystep_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      flip_ff <= flip_in;
      c_ff <= c_in;
      s_ff <= s_in;
      prod_ff <= prod_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      ys_ff <= ys_in;
      yc_ff <= yc_in;
      roll_ff <= roll_in;
      pitch_ff <= pitch_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 4'd0;
         ph_ff <= 1'b0;
         ox_ff <= 20'sd0;
         oy_ff <= 20'sd0;
         vh_ff <= 19'd49152;
         yaw_ff <= 16'sd0;
         x_ff <= 32'd0;
         y_ff <= 32'd0;
         last_z_ff <= 32'sd0;
         last_roll_ff <= 16'sd0;
         last_pitch_ff <= 16'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ph_ff <= ph_in;
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         vh_ff <= vh_in;
         yaw_ff <= yaw_in;
         x_ff <= x_in;
         y_ff <= y_in;
         last_z_ff <= last_z_in;
         last_roll_ff <= last_roll_in;
         last_pitch_ff <= last_pitch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/planar_dead_reckoning_integrator_top.sv -----
// planar dead-reckoning integrator, one item per 5 ms tick
// req channel: req_valid / req_stall / req_data (speed, yaw rate, terrain
//   height, roll and pitch); an item is taken when req_valid and not req_stall
// rsp channel: rsp_valid / rsp_stall / rsp_data (pose, attitude and rates);
//   one result per item, in order
// csr channel: csr_valid / csr_ready / csr_index / csr_wdata; the user must
//   write it only while idle, which the block does not enforce; csr_ready is
//   always high, unknown indexes are ignored; writing a start register also
//   loads the matching pose accumulator
// an item goes from acceptance to rsp_valid, with the back end idle, through
//   the input queue, two 16-step cordic passes, 14 steps of the single
//   shared multiplier (attitude, position, divide by 200), the heading wrap
//   and the output register load; the back end takes one item at a time and
//   the two-entry input queue takes new items while it works
// a stalled result holds in the output register; the back end waits on it
//   before finishing the next item, and req_stall rises once the queue fills
// reset (synchronous, active high) loads offsets 0, vehicle height 0.75 m,
//   pose zero and empties the queue and output register
`timescale 1ns / 1ps
`default_nettype none
module planar_dead_reckoning_integrator_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pdri_pkg::req_item_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pdri_pkg::rsp_item_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  pdri_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata
);
   import pdri_pkg::*;

   queue_out_type q_out;
   logic q_pop;

   assign csr_ready = 1'b1;

   pdri_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   pdri_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sim/planar_dead_reckoning_integrator_top_tb.sv -----
`timescale 1ns / 1ps
module planar_dead_reckoning_integrator_top_tb;
   import pdri_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_OFFSET_X;
   logic [31:0] csr_wdata = '0;

   planar_dead_reckoning_integrator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial forever #1 clock = ~clock;

   // predictor state
   longint off_x, off_y, veh_h;
   int yaw_st;
   logic [31:0] x_st, y_st;
   longint prev_z, prev_roll, prev_pitch;

   req_item_type tick_queue[$];
   rsp_item_type pose_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit tail_mode = 0;
   bit sender_hold = 0;
   int rsp_hold_req = 0;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic int floor_shr(int v, int s);
      return v >>> s;
   endfunction

   function automatic void sincos(input int ang, output int c, output int s);
      int z, x, y, xs, ys;
      bit flip;
      int atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
      z = ang * 8;
      x = 39797;
      y = 0;
      flip = 0;
      if (z > 102944) begin
         z -= 205887;
         flip = 1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_tab[i];
         end else begin
            x += ys; y -= xs; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   task automatic predictor_reset();
      off_x = 0; off_y = 0; veh_h = 49152;
      yaw_st = 0; x_st = 0; y_st = 0;
      prev_z = 0; prev_roll = 0; prev_pitch = 0;
   endtask

   task automatic predictor_write(input csr_index_type idx, input logic [31:0] v);
      case (idx)
         CSR_OFFSET_X: begin
            off_x = longint'($signed(v[19:0]));
         end
         CSR_OFFSET_Y: begin
            off_y = longint'($signed(v[19:0]));
         end
         CSR_VEH_HEIGHT: begin
            veh_h = longint'(v[18:0]);
         end
         CSR_INIT_X: begin
            x_st = v;
         end
         CSR_INIT_Y: begin
            y_st = v;
         end
         CSR_INIT_YAW: begin
            yaw_st = int'($signed(v[15:0]));
         end
         default: begin
         end
      endcase
   endtask

   function automatic rsp_item_type predict_pose(input req_item_type t);
      rsp_item_type r;
      longint spd, yr, th, tr, tp, rl, pt, yw, z, st, cc, ss;
      int c, s;
      spd = t.speed; yr = t.yaw_rate; th = t.terrain_height;
      tr = t.terrain_roll; tp = t.terrain_pitch;
      sincos(yaw_st, c, s);
      cc = c; ss = s;
      rl = clamp(round_div(tr * cc + tp * ss, 65536), 16);
      pt = clamp(round_div(-tr * ss + tp * cc, 65536), 16);
      yw = longint'(yaw_st) + round_div(yr, 200);
      if (yw > 25736) yw -= 51472;
      else if (yw < -25736) yw += 51472;
      yaw_st = int'(yw);
      sincos(yaw_st, c, s);
      cc = c; ss = s;
      st = round_div(cc * spd * 131072 + yr * (-ss * off_x - cc * off_y),
                     200 * (longint'(1) << 29));
      x_st = x_st + st[31:0];
      st = round_div(ss * spd * 131072 + yr * (cc * off_x - ss * off_y),
                     200 * (longint'(1) << 29));
      y_st = y_st + st[31:0];
      z = clamp(th + veh_h, 32);
      r.pos_x = x_st;
      r.pos_y = y_st;
      r.pos_z = z[31:0];
      r.roll = rl[15:0];
      r.pitch = pt[15:0];
      r.heading = yw[15:0];
      st = clamp(200 * (rl - prev_roll), 24);
      r.roll_rate = st[23:0];
      st = clamp(200 * (pt - prev_pitch), 24);
      r.pitch_rate = st[23:0];
      st = clamp(200 * (z - prev_z), 32);
      r.z_rate = st[31:0];
      prev_roll = rl; prev_pitch = pt; prev_z = z;
      return r;
   endfunction

   // acceptance flag latched at rising edge
   bit accepted_edge = 0;
   always @(posedge clock) begin
      accepted_edge <= 0;
      if (!reset && req_valid && !req_stall) begin
         accepted_edge <= 1;
         pose_queue.insert(pose_queue.size(), predict_pose(req_data));
      end
   end

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_edge) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0 && !sender_hold) begin
               req_data <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if (!tail_mode && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall
   int stall_left = 0;
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= rsp_hold_req;
         rsp_hold_req <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (!tail_mode && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(1, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = pose_queue.pop_front();
            if (rsp_data.pos_x !== e.pos_x) begin
               $error("pos_x exp %0d got %0d", e.pos_x, rsp_data.pos_x); errors++;
            end
            if (rsp_data.pos_y !== e.pos_y) begin
               $error("pos_y exp %0d got %0d", e.pos_y, rsp_data.pos_y); errors++;
            end
            if (rsp_data.pos_z !== e.pos_z) begin
               $error("pos_z exp %0d got %0d", e.pos_z, rsp_data.pos_z); errors++;
            end
            if (rsp_data.roll !== e.roll) begin
               $error("roll exp %0d got %0d", e.roll, rsp_data.roll); errors++;
            end
            if (rsp_data.pitch !== e.pitch) begin
               $error("pitch exp %0d got %0d", e.pitch, rsp_data.pitch); errors++;
            end
            if (rsp_data.heading !== e.heading) begin
               $error("heading exp %0d got %0d", e.heading, rsp_data.heading); errors++;
            end
            if (rsp_data.roll_rate !== e.roll_rate) begin
               $error("roll_rate exp %0d got %0d", e.roll_rate, rsp_data.roll_rate);
               errors++;
            end
            if (rsp_data.pitch_rate !== e.pitch_rate) begin
               $error("pitch_rate exp %0d got %0d", e.pitch_rate, rsp_data.pitch_rate);
               errors++;
            end
            if (rsp_data.z_rate !== e.z_rate) begin
               $error("z_rate exp %0d got %0d", e.z_rate, rsp_data.z_rate); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_item_type rand_tick();
      req_item_type t;
      t.speed = 16'($urandom);
      t.yaw_rate = 16'($urandom);
      t.terrain_height = $urandom;
      t.terrain_roll = 16'($urandom);
      t.terrain_pitch = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         t.speed = 16'($signed($urandom_range(0, 16384)) - 8192);
         t.yaw_rate = 16'($signed($urandom_range(0, 20000)) - 10000);
         t.terrain_height = $signed($urandom_range(0, 2000000)) - 1000000;
         t.terrain_roll = 16'($signed($urandom_range(0, 4000)) - 2000);
         t.terrain_pitch = 16'($signed($urandom_range(0, 4000)) - 2000);
      end
      return t;
   endfunction

   function automatic req_item_type make_tick(int sp, int yr, int th, int tr, int tp);
      req_item_type t;
      t.speed = 16'(sp); t.yaw_rate = 16'(yr); t.terrain_height = th;
      t.terrain_roll = 16'(tr); t.terrain_pitch = 16'(tp);
      return t;
   endfunction

   task automatic add_tick(input req_item_type t);
      tick_queue.insert(tick_queue.size(), t);
   endtask

   task automatic drain();
      while (tick_queue.size() > 0 || pose_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] v);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      predictor_write(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_config();
      csr_write(CSR_OFFSET_X, $urandom);
      csr_write(CSR_OFFSET_Y, $urandom);
      csr_write(CSR_VEH_HEIGHT, $urandom_range(0, 262144));
      csr_write(CSR_INIT_X, $urandom);
      csr_write(CSR_INIT_Y, $urandom);
      csr_write(CSR_INIT_YAW, $signed($urandom_range(0, 51472)) - 25736);
   endtask

   initial begin
      predictor_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // first ticks against reset state
      add_tick(make_tick(0, 0, 0, 0, 0));
      add_tick(make_tick(32767, 32767, 2147483647, 32767, 32767));
      add_tick(make_tick(-32768, -32768, -2147483648, -32768, -32768));
      add_tick(make_tick(-32768, 32767, 2147483647, -32768, 32767));
      drain();
      // extremes of the config
      csr_write(CSR_OFFSET_X, 32'h0007FFFF);
      csr_write(CSR_OFFSET_Y, 32'h00080000);
      csr_write(CSR_VEH_HEIGHT, 262144);
      csr_write(CSR_INIT_X, 32'h7FFFFFFF);
      csr_write(CSR_INIT_Y, 32'h80000000);
      csr_write(CSR_INIT_YAW, 25736);
      csr_write(csr_index_type'(7), 32'h12345678);
      add_tick(make_tick(32767, 32767, 2147483647, 20000, -20000));
      add_tick(make_tick(32767, 32767, 2147483647, 32767, 32767));
      add_tick(make_tick(-32768, -32768, 0, -32768, 32767));
      add_tick(make_tick(100, -32768, -2147483648, 0, 0));
      drain();
      csr_write(CSR_OFFSET_X, 32'h00080000);
      csr_write(CSR_OFFSET_Y, 32'h0007FFFF);
      csr_write(CSR_VEH_HEIGHT, 0);
      csr_write(CSR_INIT_X, 32'h80000000);
      csr_write(CSR_INIT_Y, 32'h7FFFFFFF);
      csr_write(CSR_INIT_YAW, 32'hFFFF9B78);
      csr_write(csr_index_type'(6), 32'h0);
      for (int i = 0; i < 8; i++)
         add_tick(make_tick(-32768, -32768, -2147483648, 12345, -32768));
      drain();
      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         random_config();
         for (int i = 0; i < 180; i++) add_tick(rand_tick());
         if (ph == 1) begin
            rsp_hold_req = 1500;
         end
         if (ph == 3) begin
            while (tick_queue.size() > 90) @(posedge clock);
            sender_hold = 1;
            while (pose_queue.size() > 0 || req_valid) @(posedge clock);
            sender_hold = 0;
         end
         drain();
      end
      tail_mode = 1;
      for (int i = 0; i < 100; i++) add_tick(rand_tick());
      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/pdri_pkg.sv
src/pdri_front.sv
src/pdri_core.sv
src/planar_dead_reckoning_integrator_top.sv
sim/planar_dead_reckoning_integrator_top_tb.sv
